>>> hw/rtl/swa_pkg.sv
package swa_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 11;
    localparam int NUM_LANES = 3;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 2;

    localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = 2'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample_x;
        sample_t sample_y;
        sample_t sample_z;
    } in_item_t;

    typedef struct packed {
        sample_t mean_x;
        sample_t mean_y;
        sample_t mean_z;
        sample_t peak_x;
        sample_t peak_y;
        sample_t peak_z;
        sample_t floor_x;
        sample_t floor_y;
        sample_t floor_z;
    } out_item_t;

    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_READ   = 2'd1,
        SRC_SAMPLE = 2'd2
    } lane_src_t;

    typedef struct packed {
        logic      rd_en;
        logic      wr_en;
        lane_src_t src;
        logic      acc_en;
        logic      acc_clear;
    } lane_ctrl_t;

endpackage

>>> hw/rtl/sliding_window_avg_min_max_unit.sv
// Three-axis sliding-window average, maximum and minimum. Each transfer on the input
// channel carries one x/y/z sample in signed Q4.12; each is shifted into that axis's
// window of the last window_length samples (register 0, clamped to 1..WINDOW_DEPTH),
// and one result returns the per-axis mean (truncated toward zero), maximum and minimum.
// Each axis has its own lane with a single-port-write window memory. An input transfer
// is handled in steps: the scan reads each older entry of the window, whose active length
// is n, and writes it back one place lower while summing; the new sample is written at the
// top; the divide is started; and a bit-serial divide of the sum, which is
// SW = 16 + ceil(log2(WINDOW_DEPTH)) bits wide, by n gives the mean. Input is taken only in
// the idle state, which is entered again when the result is posted, so a new item is not
// accepted before the last one is through; a result still held by the receiver stalls the
// divide stage until it is taken. After reset the windows are cleared to zero entry by
// entry, during which no input is taken. A finished result waits in an output register
// while the next item is already being accepted.
module sliding_window_avg_min_max_unit
    import swa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = SAMPLE_W + AW;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_LAST  = 6'b001000,
        ST_START = 6'b010000,
        ST_DIV   = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [LW-1:0]        cnt_reg;
    logic [LW-1:0]        cnt_next;
    logic [LW-1:0]        n_reg;
    logic [LW-1:0]        n_next;
    logic [LW-1:0]        n_clamped;
    logic [LW-1:0]        n_last;
    logic                 pend_reg;
    logic                 pend_next;
    logic [AW-1:0]        pend_addr_reg;
    logic [AW-1:0]        pend_addr_next;
    in_item_t             sample_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    out_item_t            result;
    logic                 cfg_write;
    logic                 in_xfer;
    logic                 div_start;
    lane_ctrl_t           ctrl;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    sample_t              lane_sample [NUM_LANES];
    logic signed [SW-1:0] lane_sum    [NUM_LANES];
    sample_t              lane_peak   [NUM_LANES];
    sample_t              lane_floor  [NUM_LANES];
    sample_t              lane_mean   [NUM_LANES];
    logic [NUM_LANES-1:0] div_busy;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_WINDOW_LENGTH) ? PDATA_W'(len_reg) : '0;
    assign len_next  = (cfg_write && (paddr == ADDR_WINDOW_LENGTH)) ?
                       pwdata[LEN_W-1:0] : len_reg;

    always_comb
    begin
        if (len_reg == '0)
        begin
            n_clamped = LW'(1);
        end
        else if (32'(len_reg) > WINDOW_DEPTH)
        begin
            n_clamped = LW'(WINDOW_DEPTH);
        end
        else
        begin
            n_clamped = LW'(len_reg);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign div_start = (state_reg == ST_START);
    assign n_last    = n_reg - 1'b1;

    always_comb
    begin
        ctrl.rd_en     = (state_reg == ST_SCAN) && (cnt_reg < n_reg);
        ctrl.wr_en     = (state_reg == ST_CLEAR) || (state_reg == ST_LAST) ||
                         ((state_reg == ST_SCAN) && pend_reg);
        ctrl.acc_en    = (state_reg == ST_LAST) || ((state_reg == ST_SCAN) && pend_reg);
        ctrl.acc_clear = in_xfer;
        case (state_reg)
            ST_CLEAR: ctrl.src = SRC_ZERO;
            ST_LAST:  ctrl.src = SRC_SAMPLE;
            default:  ctrl.src = SRC_READ;
        endcase
        rd_addr = cnt_reg[AW-1:0];
        case (state_reg)
            ST_CLEAR: wr_addr = cnt_reg[AW-1:0];
            ST_LAST:  wr_addr = n_last[AW-1:0];
            default:  wr_addr = pend_addr_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LW'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next     = n_clamped;
                    cnt_next   = LW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < n_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[AW-1:0] - 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy[0] && (!out_valid_reg || out_ready))
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            len_reg       <= LEN_W'(1);
            cnt_reg       <= '0;
            n_reg         <= LW'(1);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (in_xfer)
        begin
            sample_reg <= in_data;
        end
        if ((state_reg == ST_DIV) && (state_next == ST_IDLE))
        begin
            out_data_reg <= result;
        end
    end

    assign lane_sample[0] = sample_reg.sample_x;
    assign lane_sample[1] = sample_reg.sample_y;
    assign lane_sample[2] = sample_reg.sample_z;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        swa_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH),
            .AW           (AW),
            .SW           (SW)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .rd_addr   (rd_addr),
            .wr_addr   (wr_addr),
            .sample    (lane_sample[g]),
            .sum       (lane_sum[g]),
            .peak      (lane_peak[g]),
            .floor_val (lane_floor[g])
        );

        swa_div #(
            .SW (SW),
            .LW (LW)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (lane_sum[g]),
            .divisor  (n_reg),
            .busy     (div_busy[g]),
            .quotient (lane_mean[g])
        );
    end

    always_comb
    begin
        result.mean_x  = lane_mean[0];
        result.mean_y  = lane_mean[1];
        result.mean_z  = lane_mean[2];
        result.peak_x  = lane_peak[0];
        result.peak_y  = lane_peak[1];
        result.peak_z  = lane_peak[2];
        result.floor_x = lane_floor[0];
        result.floor_y = lane_floor[1];
        result.floor_z = lane_floor[2];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (div_busy[0] == div_busy[1]) && (div_busy[0] == div_busy[2]))
        else $error("lane dividers out of step");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("pending read data outside scan");

    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && pend_reg) |-> (LW'(pend_addr_reg) < n_last))
        else $error("scan write beyond window");

    a_xfer_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> ((state_reg == ST_SCAN) && (cnt_reg == LW'(1))))
        else $error("input transfer did not start a scan");

endmodule

>>> hw/rtl/swa_lane.sv
module swa_lane
    import swa_pkg::*;
#(
    parameter int WINDOW_DEPTH = 1024,
    parameter int AW           = 10,
    parameter int SW           = 26
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           ctrl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  sample_t              sample,
    output logic signed [SW-1:0] sum,
    output sample_t              peak,
    output sample_t              floor_val
);

    sample_t              mem [WINDOW_DEPTH];
    sample_t              rdata_reg;
    sample_t              wr_data;
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    sample_t              peak_reg;
    sample_t              peak_next;
    sample_t              floor_reg;
    sample_t              floor_next;

    always_comb
    begin
        case (ctrl.src)
            SRC_ZERO:   wr_data = '0;
            SRC_READ:   wr_data = rdata_reg;
            SRC_SAMPLE: wr_data = sample;
            default:    wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        peak_next  = peak_reg;
        floor_next = floor_reg;
        if (ctrl.acc_clear)
        begin
            sum_next   = '0;
            peak_next  = {1'b1, {(SAMPLE_W-1){1'b0}}};
            floor_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (ctrl.acc_en && ctrl.wr_en)
        begin
            sum_next = sum_reg + {{(SW-SAMPLE_W){wr_data[SAMPLE_W-1]}}, wr_data};
            if (wr_data > peak_reg)
            begin
                peak_next = wr_data;
            end
            if (wr_data < floor_reg)
            begin
                floor_next = wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            floor_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            peak_reg  <= peak_next;
            floor_reg <= floor_next;
        end
    end

    assign sum       = sum_reg;
    assign peak      = peak_reg;
    assign floor_val = floor_reg;

endmodule

>>> hw/rtl/swa_div.sv
module swa_div
    import swa_pkg::*;
#(
    parameter int SW = 26,
    parameter int LW = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SW-1:0] dividend,
    input  logic [LW-1:0]        divisor,
    output logic                 busy,
    output sample_t              quotient
);

    localparam int CW = $clog2(SW + 1);

    logic          busy_reg;
    logic          busy_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          neg_reg;
    logic          neg_next;
    logic [LW-1:0] dvs_reg;
    logic [LW-1:0] dvs_next;
    logic [LW-1:0] rem_reg;
    logic [LW-1:0] rem_next;
    logic [SW-1:0] quo_reg;
    logic [SW-1:0] quo_next;
    logic [SW-1:0] mag;
    logic [SW-1:0] signed_quo;
    logic [LW:0]   shifted;
    logic [LW+1:0] diff;

    assign mag     = dividend[SW-1] ? (~dividend + 1'b1) : dividend;
    assign shifted = {rem_reg, quo_reg[SW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SW);
            neg_next  = dividend[SW-1];
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = mag;
        end
        else if (busy_reg)
        begin
            if (!diff[LW+1])
            begin
                rem_next = diff[LW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[LW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[SAMPLE_W-1:0];
    assign busy       = busy_reg;

endmodule

>>> test/tb_sliding_window_avg_min_max_unit.sv
`timescale 1ns / 100ps

module tb_sliding_window_avg_min_max_unit;
    import swa_pkg::*;

    localparam int WINDOW_DEPTH = 1024;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS_PER_MIX = 125;
    localparam int LANE_OVERHEAD = 40;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 2'd3;
    localparam logic [LEN_W-1:0] LEN_ALL_ONES = '1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    sample_t axis_store [NUM_LANES][WINDOW_DEPTH];
    logic [LEN_W-1:0] window_length_reg;
    out_item_t window_stats_due [$];

    int error_count;
    int samples_sent;
    int results_checked;
    int longest_window;
    int cycle_count;
    int src_idle_pct;
    int sink_stall_pct;
    int stall_left;

    sliding_window_avg_min_max_unit #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int active_length();
        int n;
        n = window_length_reg;
        if (n < 1)
            n = 1;
        if (n > WINDOW_DEPTH)
            n = WINDOW_DEPTH;
        return n;
    endfunction

    function automatic out_item_t predict_window_stats(input in_item_t s);
        sample_t incoming [NUM_LANES];
        sample_t mean_v [NUM_LANES];
        sample_t peak_v [NUM_LANES];
        sample_t floor_v [NUM_LANES];
        out_item_t r;
        int n;
        int sum;
        int a;
        int i;
        n = active_length();
        incoming[0] = s.sample_x;
        incoming[1] = s.sample_y;
        incoming[2] = s.sample_z;
        for (a = 0; a < NUM_LANES; a++)
        begin
            for (i = 1; i < n; i++)
                axis_store[a][i - 1] = axis_store[a][i];
            axis_store[a][n - 1] = incoming[a];
            sum = 0;
            peak_v[a] = axis_store[a][0];
            floor_v[a] = axis_store[a][0];
            for (i = 0; i < n; i++)
            begin
                sum += axis_store[a][i];
                if (axis_store[a][i] > peak_v[a])
                    peak_v[a] = axis_store[a][i];
                if (axis_store[a][i] < floor_v[a])
                    floor_v[a] = axis_store[a][i];
            end
            mean_v[a] = sample_t'(sum / n);
        end
        r.mean_x = mean_v[0];
        r.mean_y = mean_v[1];
        r.mean_z = mean_v[2];
        r.peak_x = peak_v[0];
        r.peak_y = peak_v[1];
        r.peak_z = peak_v[2];
        r.floor_x = floor_v[0];
        r.floor_y = floor_v[1];
        r.floor_z = floor_v[2];
        return r;
    endfunction

    function automatic sample_t random_axis_value();
        case ($urandom_range(11))
            0: return sample_t'(16'h7FFF);
            1: return sample_t'(16'h8000);
            2: return sample_t'(16'h0000);
            3: return sample_t'(16'hFFFF);
            4: return sample_t'(int'($urandom_range(6)) - 3);
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic check_field(input string name, input sample_t want, input sample_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic send_sample(input in_item_t s);
        int gap;
        if ($urandom_range(99) < src_idle_pct)
        begin
            gap = $urandom_range(1, active_length() + LANE_OVERHEAD);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        window_stats_due.push_back(predict_window_stats(s));
        samples_sent++;
        if (active_length() > longest_window)
            longest_window = active_length();
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid = 1'b0;
        while (window_stats_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_WINDOW_LENGTH)
            window_length_reg = value[LEN_W-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_length_readback();
        logic [PDATA_W-1:0] got;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_WINDOW_LENGTH;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got[LEN_W-1:0] !== window_length_reg)
        begin
            $error("window_length: expected %0d, got %0d", window_length_reg, got[LEN_W-1:0]);
            error_count++;
        end
    endtask

    task automatic set_window_length(input logic [PDATA_W-1:0] value);
        wait_results_drained();
        write_reg(ADDR_WINDOW_LENGTH, value);
        check_length_readback();
    endtask

    task automatic test_extreme_samples();
        check_length_readback();
        send_sample({16'h7FFF, 16'h8000, 16'h0000});
        send_sample({16'h8000, 16'h7FFF, 16'hFFFF});
        send_sample({16'h5555, 16'hAAAA, 16'h0001});
        send_sample({16'hAAAA, 16'h5555, 16'h8001});
    endtask

    task automatic test_unfilled_window();
        set_window_length(32'd4);
        send_sample({16'hFFFF, 16'h7FFF, 16'h8000});
        send_sample({16'hFFFD, 16'h8000, 16'h7FFF});
        send_sample({16'h0001, 16'h0000, 16'hFFFF});
    endtask

    task automatic test_length_clamp();
        set_window_length(32'd0);
        send_sample({16'h1234, 16'hFEDC, 16'h8000});
        send_sample({16'hFFFE, 16'h0002, 16'h7FFF});
        wait_results_drained();
        write_reg(ADDR_UNMAPPED, 32'd5);
        check_length_readback();
        send_sample({16'h0003, 16'hFFFD, 16'h4000});
        set_window_length(32'hFFFF_FFFF);
        send_sample({16'h8000, 16'h7FFF, 16'hFFFF});
        send_sample({16'h8000, 16'h7FFF, 16'h0001});
        send_sample({16'h7FFF, 16'h8000, 16'hFFFF});
        set_window_length(WINDOW_DEPTH);
        send_sample({16'h8000, 16'h8000, 16'h8000});
        send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF});
    endtask

    task automatic test_length_change();
        set_window_length(32'd3);
        send_sample({16'h0010, 16'hFFF0, 16'h0000});
        send_sample({16'hFFFF, 16'h0001, 16'h8000});
        send_sample({16'h0000, 16'h0000, 16'h7FFF});
        set_window_length(32'd6);
        send_sample({16'h2000, 16'hE000, 16'h0005});
        send_sample({16'hFFFB, 16'h0007, 16'hC000});
        send_sample({16'h0001, 16'hFFFF, 16'h3FFF});
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        in_item_t s;
        int sent;
        int batch;
        int batch_len;
        int len_value;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        batch = 0;
        while (sent < RANDOM_ITEMS_PER_MIX)
        begin
            if (batch == 1)
            begin
                case ($urandom_range(2))
                    0: len_value = WINDOW_DEPTH;
                    1: len_value = LEN_ALL_ONES;
                    default: len_value = $urandom_range(WINDOW_DEPTH / 2, WINDOW_DEPTH + 200);
                endcase
                batch_len = $urandom_range(3, 6);
            end
            else
            begin
                len_value = $urandom_range(0, 24);
                batch_len = $urandom_range(12, 30);
            end
            set_window_length(($urandom() & 32'hFFFF_F800) | PDATA_W'(len_value));
            repeat (batch_len)
            begin
                s.sample_x = random_axis_value();
                s.sample_y = random_axis_value();
                s.sample_z = random_axis_value();
                send_sample(s);
                sent++;
            end
            batch++;
        end
    endtask

    // hold ready low at random, now and then for a long stretch
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(99) < sink_stall_pct)
        begin
            out_ready <= 1'b0;
            if ($urandom_range(15) == 0)
                stall_left <= $urandom_range(active_length() + LANE_OVERHEAD);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (window_stats_due.size() == 0)
            begin
                $error("result transfer with no sample pending: %h", out_data);
                error_count++;
            end
            else
            begin
                want = window_stats_due.pop_front();
                check_field("mean_x", want.mean_x, out_data.mean_x);
                check_field("mean_y", want.mean_y, out_data.mean_y);
                check_field("mean_z", want.mean_z, out_data.mean_z);
                check_field("peak_x", want.peak_x, out_data.peak_x);
                check_field("peak_y", want.peak_y, out_data.peak_y);
                check_field("peak_z", want.peak_z, out_data.peak_z);
                check_field("floor_x", want.floor_x, out_data.floor_x);
                check_field("floor_y", want.floor_y, out_data.floor_y);
                check_field("floor_z", want.floor_z, out_data.floor_z);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, window_stats_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int a;
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        samples_sent = 0;
        results_checked = 0;
        longest_window = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        stall_left = 0;
        window_length_reg = 1;
        for (a = 0; a < NUM_LANES; a++)
            for (i = 0; i < WINDOW_DEPTH; i++)
                axis_store[a][i] = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_extreme_samples();
        test_unfilled_window();
        test_length_clamp();
        test_length_change();
        test_random_traffic(0, 0);
        test_random_traffic(50, 0);
        test_random_traffic(0, 50);
        test_random_traffic(13, 13);

        wait_results_drained();
        repeat (active_length() + LANE_OVERHEAD) @(negedge clk);
        if (window_stats_due.size() != 0)
        begin
            $error("%0d expected results never arrived", window_stats_due.size());
            error_count++;
        end

        $display("%0d samples sent, %0d results checked, windows up to %0d entries,",
                 samples_sent, results_checked, longest_window);
        $display("under four sender idle / receiver stall mixes; %0d errors", error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
